### sv/jrt_pkg.sv
package jrt_pkg;

    localparam int JRT_DEPTH = 64;
    localparam int TOTAL_W   = 22;
    localparam int DUR_W     = 16;
    localparam int OPER_W    = 8;
    localparam int S_DATA_W  = 72;
    localparam int M_DATA_W  = 24;

    localparam logic [3:0] OP_INSERT     = 4'd0;
    localparam logic [3:0] OP_SET_JOB    = 4'd1;
    localparam logic [3:0] OP_SET_OPER   = 4'd2;
    localparam logic [3:0] OP_SET_MACH   = 4'd3;
    localparam logic [3:0] OP_SET_DUR    = 4'd4;
    localparam logic [3:0] OP_REM_JOB    = 4'd5;
    localparam logic [3:0] OP_REM_OPER   = 4'd6;
    localparam logic [3:0] OP_REM_ENTRY  = 4'd7;
    localparam logic [3:0] OP_CHK_JOB    = 4'd8;
    localparam logic [3:0] OP_CHK_OPER   = 4'd9;
    localparam logic [3:0] OP_CHK_ENTRY  = 4'd10;
    localparam logic [3:0] OP_TOTAL      = 4'd11;

    localparam logic [1:0] LVL_NONE  = 2'd0;
    localparam logic [1:0] LVL_JOB   = 2'd1;
    localparam logic [1:0] LVL_OPER  = 2'd2;
    localparam logic [1:0] LVL_ENTRY = 2'd3;

    typedef struct packed {
        logic [15:0]       job;
        logic [OPER_W-1:0] oper;
        logic [7:0]        mach;
        logic [DUR_W-1:0]  dur;
    } rec_t;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [15:0] job;
        logic [7:0]  oper;
        logic [7:0]  mach;
        logic [15:0] dur;
        logic [15:0] nval;
    } cmd_t;

    function automatic logic [1:0] op_level(logic [3:0] opcode);
        logic [1:0] lvl;
        unique case (opcode)
            OP_SET_JOB, OP_REM_JOB, OP_CHK_JOB:                 lvl = LVL_JOB;
            OP_SET_OPER, OP_REM_OPER, OP_CHK_OPER:              lvl = LVL_OPER;
            OP_SET_MACH, OP_SET_DUR, OP_REM_ENTRY, OP_CHK_ENTRY: lvl = LVL_ENTRY;
            default:                                            lvl = LVL_NONE;
        endcase
        return lvl;
    endfunction

    function automatic logic rec_match(logic [1:0] lvl, rec_t r, cmd_t c);
        logic hit;
        hit = (r.job == c.job);
        if (lvl == LVL_OPER || lvl == LVL_ENTRY) begin
            hit = hit && (r.oper == c.oper);
        end
        if (lvl == LVL_ENTRY) begin
            hit = hit && (r.mach == c.mach);
        end
        return hit;
    endfunction

endpackage

### sv/job_record_table.sv
// Channel | Ports                      | Transaction contents
// --------+----------------------------+-----------------------------------------------
// input   | s_tvalid s_tready s_tdata  | one command: opcode, match keys, values
// result  | m_tvalid m_tready m_tdata  | one reply per command: status, found, total
//
// Insert and unused opcodes skip the table and go straight to the done state. Updates,
// checks, job/operation removal and total take one pass over the table through
// the record memory's single read port. Removing one entry takes two passes
// (locate, then compact) when a match exists, else only the locate pass.
// Reset clears the control state and record count; the record memory needs no clearing pass.
// A result waiting in the output register does not block the next command; the
// finished command holds in its last state until the output register frees up.
module job_record_table #(
    parameter int DEPTH = jrt_pkg::JRT_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [3:0] opcode, [19:4] job_id, [27:20] operation_id, [35:28] machine_id,
    // [51:36] duration, [67:52] new_value, [71:68] zero
    input  logic [jrt_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] status, [1] found, [23:2] total_time
    output logic [jrt_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Record memory: one write port and one registered read port.
    jrt_pkg::rec_t mem [DEPTH];
    jrt_pkg::rec_t rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    jrt_pkg::rec_t wr_data;

    logic [1:0]     state_reg, state_next;
    jrt_pkg::cmd_t  cmd_reg, cmd_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  issued_reg, issued_next;
    logic           pend_reg, pend_next;
    logic [AW-1:0]  pend_addr_reg, pend_addr_next;
    logic [CW-1:0]  wr_idx_reg, wr_idx_next;
    logic           phase_reg, phase_next;
    logic [AW-1:0]  skip_reg, skip_next;
    logic           skip_vld_reg, skip_vld_next;
    logic           found_reg, found_next;
    logic           status_reg, status_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [jrt_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    jrt_pkg::cmd_t  in_cmd;
    jrt_pkg::rec_t  in_rec;
    jrt_pkg::rec_t  mod_rec;
    logic           s_accept;
    logic           full;
    logic           scan_more;
    logic           backward;
    logic [CW-1:0]  back_idx;
    logic [1:0]     lvl;
    logic           hit;
    logic           pass_done;
    logic           out_free;
    logic           acc_valid;
    logic [jrt_pkg::TOTAL_W-1:0] acc_total;
    logic [jrt_pkg::TOTAL_W-1:0] total_out;

    assign in_cmd.opcode = s_tdata[3:0];
    assign in_cmd.job    = s_tdata[19:4];
    assign in_cmd.oper   = s_tdata[27:20];
    assign in_cmd.mach   = s_tdata[35:28];
    assign in_cmd.dur    = s_tdata[51:36];
    assign in_cmd.nval   = s_tdata[67:52];

    assign in_rec.job  = in_cmd.job;
    assign in_rec.oper = in_cmd.oper;
    assign in_rec.mach = in_cmd.mach;
    assign in_rec.dur  = in_cmd.dur;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign full     = (count_reg == CW'(DEPTH));
    assign out_free = !m_tvalid_reg || m_tready;

    // Walk oldest to newest, except total which walks newest first.
    assign scan_more = (issued_reg < count_reg);
    assign backward  = (cmd_reg.opcode == jrt_pkg::OP_TOTAL);
    assign back_idx  = count_reg - issued_reg - CW'(1);
    assign rd_addr   = backward ? back_idx[AW-1:0] : issued_reg[AW-1:0];
    assign rd_en     = (state_reg == ST_SCAN) && scan_more;
    assign pass_done = (state_reg == ST_SCAN) && !scan_more && !pend_reg;

    assign lvl = jrt_pkg::op_level(cmd_reg.opcode);
    assign hit = jrt_pkg::rec_match(lvl, rd_data_reg, cmd_reg);

    assign acc_valid = (state_reg == ST_SCAN) && pend_reg && backward;
    assign total_out = (cmd_reg.opcode == jrt_pkg::OP_TOTAL) ? acc_total : '0;

    // Rewrite the field that the update command targets.
    always_comb begin
        mod_rec = rd_data_reg;
        unique case (cmd_reg.opcode)
            jrt_pkg::OP_SET_JOB:  mod_rec.job  = cmd_reg.nval;
            jrt_pkg::OP_SET_OPER: mod_rec.oper = cmd_reg.nval[7:0];
            jrt_pkg::OP_SET_MACH: mod_rec.mach = cmd_reg.nval[7:0];
            default:              mod_rec.dur  = cmd_reg.dur;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        issued_next    = issued_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        wr_idx_next    = wr_idx_reg;
        phase_next     = phase_reg;
        skip_next      = skip_reg;
        skip_vld_next  = skip_vld_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[AW-1:0];
        wr_data        = in_rec;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    cmd_next      = in_cmd;
                    found_next    = 1'b0;
                    status_next   = 1'b0;
                    issued_next   = '0;
                    pend_next     = 1'b0;
                    wr_idx_next   = '0;
                    phase_next    = 1'b0;
                    skip_vld_next = 1'b0;
                    if (in_cmd.opcode == jrt_pkg::OP_INSERT) begin
                        // Append as the newest record, or refuse when full.
                        if (full) begin
                            status_next = 1'b1;
                        end else begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        state_next = ST_DONE;
                    end else if (in_cmd.opcode > jrt_pkg::OP_TOTAL) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                // Issue the next read; the data lands in the next cycle.
                pend_next = rd_en;
                if (rd_en) begin
                    issued_next    = issued_reg + CW'(1);
                    pend_addr_next = rd_addr;
                end

                if (pend_reg) begin
                    unique case (cmd_reg.opcode)
                        jrt_pkg::OP_SET_JOB, jrt_pkg::OP_SET_OPER,
                        jrt_pkg::OP_SET_MACH, jrt_pkg::OP_SET_DUR: begin
                            // Write back in place on a match.
                            wr_en   = hit;
                            wr_addr = pend_addr_reg;
                            wr_data = mod_rec;
                        end
                        jrt_pkg::OP_REM_JOB, jrt_pkg::OP_REM_OPER: begin
                            // Compact: keep survivors, drop matches.
                            wr_addr = wr_idx_reg[AW-1:0];
                            wr_data = rd_data_reg;
                            if (!hit) begin
                                wr_en       = 1'b1;
                                wr_idx_next = wr_idx_reg + CW'(1);
                            end
                        end
                        jrt_pkg::OP_REM_ENTRY: begin
                            wr_addr = wr_idx_reg[AW-1:0];
                            wr_data = rd_data_reg;
                            if (!phase_reg) begin
                                // Locate the newest match; later hits overwrite.
                                if (hit) begin
                                    skip_next     = pend_addr_reg;
                                    skip_vld_next = 1'b1;
                                end
                            end else if (pend_addr_reg != skip_reg) begin
                                wr_en       = 1'b1;
                                wr_idx_next = wr_idx_reg + CW'(1);
                            end
                        end
                        jrt_pkg::OP_CHK_JOB, jrt_pkg::OP_CHK_OPER,
                        jrt_pkg::OP_CHK_ENTRY: begin
                            if (hit) begin
                                found_next = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                if (pass_done) begin
                    priority if (cmd_reg.opcode == jrt_pkg::OP_REM_ENTRY && !phase_reg) begin
                        if (skip_vld_reg) begin
                            phase_next  = 1'b1;
                            issued_next = '0;
                            wr_idx_next = '0;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end else if (cmd_reg.opcode == jrt_pkg::OP_REM_JOB ||
                                 cmd_reg.opcode == jrt_pkg::OP_REM_OPER ||
                                 cmd_reg.opcode == jrt_pkg::OP_REM_ENTRY) begin
                        count_next = wr_idx_reg;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                // Hold until the output register can take the result.
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {total_out, found_reg, status_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cmd_reg       <= cmd_next;
        issued_reg    <= issued_next;
        pend_addr_reg <= pend_addr_next;
        wr_idx_reg    <= wr_idx_next;
        phase_reg     <= phase_next;
        skip_reg      <= skip_next;
        skip_vld_reg  <= skip_vld_next;
        found_reg     <= found_next;
        status_reg    <= status_next;
        m_tdata_reg   <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    jrt_runmax u_runmax (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (s_accept),
        .rec_valid (acc_valid),
        .rec_oper  (rd_data_reg.oper),
        .rec_dur   (rd_data_reg.dur),
        .total     (acc_total)
    );

endmodule

### sv/jrt_runmax.sv
// Run-maximum accumulator: sums the largest duration of each run of equal
// operations, fed newest record first.
module jrt_runmax (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           clear,
    input  logic                           rec_valid,
    input  logic [jrt_pkg::OPER_W-1:0]     rec_oper,
    input  logic [jrt_pkg::DUR_W-1:0]      rec_dur,
    output logic [jrt_pkg::TOTAL_W-1:0]    total
);

    logic                          have_reg, have_next;
    logic [jrt_pkg::OPER_W-1:0]    run_oper_reg, run_oper_next;
    logic [jrt_pkg::DUR_W-1:0]     best_reg, best_next;
    logic [jrt_pkg::TOTAL_W-1:0]   sum_reg, sum_next;
    logic [jrt_pkg::TOTAL_W:0]     sum_wide;
    logic [jrt_pkg::TOTAL_W-1:0]   sum_sat;

    // Close the current run into the sum, saturating at the top of the range.
    assign sum_wide = {1'b0, sum_reg} + (jrt_pkg::TOTAL_W + 1)'(best_reg);
    assign sum_sat  = sum_wide[jrt_pkg::TOTAL_W] ? '1 : sum_wide[jrt_pkg::TOTAL_W-1:0];
    assign total    = sum_sat;

    always_comb begin
        have_next     = have_reg;
        run_oper_next = run_oper_reg;
        best_next     = best_reg;
        sum_next      = sum_reg;
        if (clear) begin
            have_next = 1'b0;
            best_next = '0;
            sum_next  = '0;
        end else if (rec_valid) begin
            if (have_reg && rec_oper == run_oper_reg) begin
                if (rec_dur > best_reg) begin
                    best_next = rec_dur;
                end
            end else begin
                sum_next      = sum_sat;
                run_oper_next = rec_oper;
                best_next     = rec_dur;
                have_next     = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
            best_reg <= '0;
            sum_reg  <= '0;
        end else begin
            have_reg <= have_next;
            best_reg <= best_next;
            sum_reg  <= sum_next;
        end
        run_oper_reg <= run_oper_next;
    end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF      = 6;
    localparam int RANDOM_ITEMS  = 1300;
    // Two passes over a full table plus margin.
    localparam int DRAIN_CYCLES  = 2 * jrt_pkg::JRT_DEPTH + 72;
    localparam int TOTAL_CAP     = (1 << jrt_pkg::TOTAL_W) - 1;
    localparam logic [3:0] OP_MAX_CODE = 4'hF;

    typedef enum int { PH_FILL, PH_MIX, PH_DRAIN } phase_t;

    // One reply as the block packs it, highest field first: total_time, found, status.
    typedef struct packed {
        logic [jrt_pkg::TOTAL_W-1:0] total;
        logic                        found;
        logic                        status;
    } reply_t;

    // Scoreboard: keeps its own copy of the record table (oldest at index 0),
    // predicts one reply per accepted command and checks replies in order.
    class job_table_scoreboard;
        jrt_pkg::rec_t rows[$];
        reply_t        replies_due[$];
        int            errors;

        function new();
            errors = 0;
        endfunction

        function logic [1:0] key_depth(logic [3:0] opcode);
            case (opcode)
                jrt_pkg::OP_SET_JOB, jrt_pkg::OP_REM_JOB, jrt_pkg::OP_CHK_JOB:
                    return jrt_pkg::LVL_JOB;
                jrt_pkg::OP_SET_OPER, jrt_pkg::OP_REM_OPER, jrt_pkg::OP_CHK_OPER:
                    return jrt_pkg::LVL_OPER;
                jrt_pkg::OP_SET_MACH, jrt_pkg::OP_SET_DUR, jrt_pkg::OP_REM_ENTRY,
                jrt_pkg::OP_CHK_ENTRY:
                    return jrt_pkg::LVL_ENTRY;
                default:
                    return jrt_pkg::LVL_NONE;
            endcase
        endfunction

        function bit key_hit(jrt_pkg::rec_t r, logic [1:0] lvl, jrt_pkg::cmd_t c);
            if (r.job != c.job) return 0;
            if ((lvl == jrt_pkg::LVL_OPER || lvl == jrt_pkg::LVL_ENTRY) && r.oper != c.oper)
                return 0;
            if (lvl == jrt_pkg::LVL_ENTRY && r.mach != c.mach) return 0;
            return 1;
        endfunction

        function void accept_command(jrt_pkg::cmd_t c);
            reply_t        r;
            jrt_pkg::rec_t row;
            jrt_pkg::rec_t kept[$];
            logic [1:0]    lvl;
            int            i;
            int            victim;
            int            sum;
            int            best;
            logic [7:0]    run_oper;
            bit            have;
            r   = '0;
            lvl = key_depth(c.opcode);
            case (c.opcode)
                jrt_pkg::OP_INSERT: begin
                    if (rows.size() >= jrt_pkg::JRT_DEPTH) begin
                        r.status = 1'b1;
                    end else begin
                        row.job  = c.job;
                        row.oper = c.oper;
                        row.mach = c.mach;
                        row.dur  = c.dur;
                        rows.push_back(row);
                    end
                end
                jrt_pkg::OP_SET_JOB, jrt_pkg::OP_SET_OPER, jrt_pkg::OP_SET_MACH,
                jrt_pkg::OP_SET_DUR: begin
                    foreach (rows[k]) begin
                        if (key_hit(rows[k], lvl, c)) begin
                            case (c.opcode)
                                jrt_pkg::OP_SET_JOB:  rows[k].job  = c.nval;
                                jrt_pkg::OP_SET_OPER: rows[k].oper = c.nval[7:0];
                                jrt_pkg::OP_SET_MACH: rows[k].mach = c.nval[7:0];
                                default:              rows[k].dur  = c.dur;
                            endcase
                        end
                    end
                end
                jrt_pkg::OP_REM_JOB, jrt_pkg::OP_REM_OPER: begin
                    foreach (rows[k]) begin
                        if (!key_hit(rows[k], lvl, c)) kept.push_back(rows[k]);
                    end
                    rows = kept;
                end
                jrt_pkg::OP_REM_ENTRY: begin
                    // Drop only the newest match.
                    victim = -1;
                    for (i = rows.size() - 1; i >= 0 && victim < 0; i--) begin
                        if (key_hit(rows[i], lvl, c)) victim = i;
                    end
                    if (victim >= 0) rows.delete(victim);
                end
                jrt_pkg::OP_CHK_JOB, jrt_pkg::OP_CHK_OPER, jrt_pkg::OP_CHK_ENTRY: begin
                    foreach (rows[k]) begin
                        if (key_hit(rows[k], lvl, c)) r.found = 1'b1;
                    end
                end
                jrt_pkg::OP_TOTAL: begin
                    // Walk newest to oldest; add the maximum of each operation run.
                    sum      = 0;
                    best     = 0;
                    run_oper = '0;
                    have     = 0;
                    for (i = rows.size() - 1; i >= 0; i--) begin
                        if (have && rows[i].oper == run_oper) begin
                            if (int'(rows[i].dur) > best) best = int'(rows[i].dur);
                        end else begin
                            sum = sum + best;
                            if (sum > TOTAL_CAP) sum = TOTAL_CAP;
                            run_oper = rows[i].oper;
                            best     = int'(rows[i].dur);
                            have     = 1;
                        end
                    end
                    sum = sum + best;
                    if (sum > TOTAL_CAP) sum = TOTAL_CAP;
                    r.total = sum[jrt_pkg::TOTAL_W-1:0];
                end
                default: ;
            endcase
            replies_due.push_back(r);
        endfunction

        function void check_reply(logic [jrt_pkg::M_DATA_W-1:0] d);
            reply_t got;
            reply_t want;
            got = d[jrt_pkg::TOTAL_W+1:0];
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected reply: expected none, actual 0x%06h", $time, d);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.found !== want.found) begin
                $display("%0t: found mismatch: expected %0d, actual %0d",
                         $time, want.found, got.found);
                errors++;
            end
            if (got.total !== want.total) begin
                $display("%0t: total_time mismatch: expected %0d, actual %0d",
                         $time, want.total, got.total);
                errors++;
            end
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [jrt_pkg::S_DATA_W-1:0]  s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [jrt_pkg::M_DATA_W-1:0]  m_tdata;

    job_table_scoreboard   scoreboard;

    // Key pools, reshuffled per phase so that matches, runs and removals happen
    // often while every key bit still gets exercised.
    logic [15:0] job_pool  [4];
    logic [7:0]  oper_pool [3];
    logic [7:0]  mach_pool [3];

    job_record_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Pack fields lowest first: opcode, job, operation, machine, duration, new value.
    function automatic logic [jrt_pkg::S_DATA_W-1:0] pack_cmd(jrt_pkg::cmd_t c);
        return {4'b0000, c.nval, c.dur, c.mach, c.oper, c.job, c.opcode};
    endfunction

    function automatic jrt_pkg::cmd_t make_cmd(logic [3:0] op, logic [15:0] job,
                                               logic [7:0] oper, logic [7:0] mach,
                                               logic [15:0] dur, logic [15:0] nval);
        jrt_pkg::cmd_t c;
        c.opcode = op;
        c.job    = job;
        c.oper   = oper;
        c.mach   = mach;
        c.dur    = dur;
        c.nval   = nval;
        return c;
    endfunction

    // Present one transaction and hold it until the block takes it.
    task automatic send_cmd(jrt_pkg::cmd_t c);
        s_tvalid <= 1'b1;
        s_tdata  <= pack_cmd(c);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid for the requested gap, if any; scribble on the data bus meanwhile.
    task automatic idle_gap(int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {4'b0000, 36'($urandom()), 32'($urandom())};
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic send_fields(logic [3:0] op, logic [15:0] job, logic [7:0] oper,
                               logic [7:0] mach, logic [15:0] dur, logic [15:0] nval);
        send_cmd(make_cmd(op, job, oper, mach, dur, nval));
        idle_gap($urandom_range(0, 3));
    endtask

    task automatic reshuffle_pools();
        foreach (job_pool[k])  job_pool[k]  = 16'($urandom());
        foreach (oper_pool[k]) oper_pool[k] = 8'($urandom());
        foreach (mach_pool[k]) mach_pool[k] = 8'($urandom());
    endtask

    function automatic logic [15:0] pick_job();
        if ($urandom_range(0, 99) < 85) return job_pool[$urandom_range(0, 3)];
        return 16'($urandom());
    endfunction

    function automatic logic [7:0] pick_oper();
        if ($urandom_range(0, 99) < 85) return oper_pool[$urandom_range(0, 2)];
        return 8'($urandom());
    endfunction

    function automatic logic [7:0] pick_mach();
        if ($urandom_range(0, 99) < 85) return mach_pool[$urandom_range(0, 2)];
        return 8'($urandom());
    endfunction

    function automatic jrt_pkg::cmd_t random_cmd(phase_t ph);
        jrt_pkg::cmd_t c;
        int            r;
        int            dsel;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL: begin
                c.opcode = (r < 70) ? jrt_pkg::OP_INSERT
                                    : 4'($urandom_range(jrt_pkg::OP_SET_JOB, OP_MAX_CODE));
            end
            PH_DRAIN: begin
                if (r < 10)      c.opcode = jrt_pkg::OP_INSERT;
                else if (r < 60) c.opcode = 4'($urandom_range(jrt_pkg::OP_REM_JOB,
                                                               jrt_pkg::OP_REM_ENTRY));
                else             c.opcode = 4'($urandom_range(jrt_pkg::OP_SET_JOB,
                                                               OP_MAX_CODE));
            end
            default: begin
                if (r < 30)      c.opcode = jrt_pkg::OP_INSERT;
                else if (r < 90) c.opcode = 4'($urandom_range(jrt_pkg::OP_SET_JOB,
                                                               jrt_pkg::OP_TOTAL));
                else if (r < 95) c.opcode = jrt_pkg::OP_TOTAL;
                else             c.opcode = 4'($urandom_range(jrt_pkg::OP_TOTAL + 1,
                                                               OP_MAX_CODE));
            end
        endcase
        c.job  = pick_job();
        c.oper = pick_oper();
        c.mach = pick_mach();
        dsel   = $urandom_range(0, 9);
        if (dsel == 0)      c.dur = 16'h0000;
        else if (dsel == 1) c.dur = 16'hFFFF;
        else                c.dur = 16'($urandom());
        // Aim replacement values at the pools so updates merge records.
        case (c.opcode)
            jrt_pkg::OP_SET_JOB:
                c.nval = ($urandom_range(0, 1) != 0) ? pick_job() : 16'($urandom());
            jrt_pkg::OP_SET_OPER: c.nval = {8'($urandom()), pick_oper()};
            jrt_pkg::OP_SET_MACH: c.nval = {8'($urandom()), pick_mach()};
            default:              c.nval = 16'($urandom());
        endcase
        return c;
    endfunction

    // Monitor: note accepted commands before checking replies at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                scoreboard.accept_command(make_cmd(s_tdata[3:0], s_tdata[19:4],
                                                   s_tdata[27:20], s_tdata[35:28],
                                                   s_tdata[51:36], s_tdata[67:52]));
            end
            if (m_tvalid && m_tready) begin
                scoreboard.check_reply(m_tdata);
            end
        end
    end

    // Receiver: ready stretches of random length, broken by stalls, with an
    // occasional long stretch of no stalling at all.
    initial begin
        int run_len;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 400)
                                                  : $urandom_range(1, 20);
            m_tready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            if ($urandom_range(0, 3) != 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #12_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int     sent;
        int     phase_len;
        int     burst;
        phase_t ph;
        scoreboard = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty table, field extremes, every opcode, newest-only
        // removal, merging updates and removals that match nothing.
        send_fields(jrt_pkg::OP_TOTAL,     16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_fields(jrt_pkg::OP_CHK_JOB,   16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_fields(jrt_pkg::OP_INSERT,    16'h0000, 8'h00, 8'h00, 16'h0000, 16'hFFFF);
        send_fields(jrt_pkg::OP_INSERT,    16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'h0000);
        send_fields(jrt_pkg::OP_INSERT,    16'h1234, 8'h05, 8'h07, 16'd100,  16'h0000);
        send_fields(jrt_pkg::OP_INSERT,    16'h1234, 8'h05, 8'h07, 16'd300,  16'h0000);
        send_fields(jrt_pkg::OP_INSERT,    16'h1234, 8'h09, 8'h02, 16'd50,   16'h0000);
        send_fields(jrt_pkg::OP_TOTAL,     16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_fields(jrt_pkg::OP_CHK_JOB,   16'h1234, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_fields(jrt_pkg::OP_CHK_OPER,  16'h1234, 8'h09, 8'h00, 16'h0000, 16'h0000);
        send_fields(jrt_pkg::OP_CHK_ENTRY, 16'h1234, 8'h05, 8'h08, 16'h0000, 16'h0000);
        send_fields(jrt_pkg::OP_SET_DUR,   16'h1234, 8'h05, 8'h07, 16'hFFFF, 16'h0000);
        send_fields(jrt_pkg::OP_SET_MACH,  16'h1234, 8'h09, 8'h02, 16'h0000, 16'hAB07);
        send_fields(jrt_pkg::OP_SET_OPER,  16'h1234, 8'h09, 8'h00, 16'h0000, 16'h0105);
        send_fields(jrt_pkg::OP_TOTAL,     16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_fields(jrt_pkg::OP_REM_ENTRY, 16'h1234, 8'h05, 8'h07, 16'h0000, 16'h0000);
        send_fields(jrt_pkg::OP_CHK_ENTRY, 16'h1234, 8'h05, 8'h07, 16'h0000, 16'h0000);
        send_fields(jrt_pkg::OP_SET_JOB,   16'hFFFF, 8'h00, 8'h00, 16'h0000, 16'h1234);
        send_fields(jrt_pkg::OP_REM_OPER,  16'h1234, 8'h05, 8'h00, 16'h0000, 16'h0000);
        send_fields(jrt_pkg::OP_REM_JOB,   16'h5555, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_fields(4'(jrt_pkg::OP_TOTAL + 1),
                                           16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_fields(OP_MAX_CODE,           16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_fields(jrt_pkg::OP_REM_JOB,   16'h1234, 8'h00, 8'h00, 16'h0000, 16'h0000);
        send_fields(jrt_pkg::OP_TOTAL,     16'h0000, 8'h00, 8'h00, 16'h0000, 16'h0000);

        // Random: phases that fill the table past full, mix everything, or
        // drain it; bursts of back-to-back transactions between idle gaps.
        sent = 0;
        ph   = PH_FILL;
        while (sent < RANDOM_ITEMS) begin
            reshuffle_pools();
            phase_len = (ph == PH_FILL) ? $urandom_range(90, 150) : $urandom_range(40, 120);
            while (phase_len > 0 && sent < RANDOM_ITEMS) begin
                burst = $urandom_range(1, 16);
                while (burst > 0 && phase_len > 0) begin
                    send_cmd(random_cmd(ph));
                    burst--;
                    phase_len--;
                    sent++;
                end
                if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
            end
            case ($urandom_range(0, 2))
                0:       ph = PH_FILL;
                1:       ph = PH_DRAIN;
                default: ph = PH_MIX;
            endcase
        end
        idle_gap(1);

        // Wait out outstanding replies, then watch for strays.
        while (scoreboard.replies_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (scoreboard.errors == 0 && scoreboard.replies_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
